### hdl/ctqs_pkg.sv
// Package for the contour-to-quadratic segment core.
// Holds coordinate width, segment kind codes, segment and queue entry types.
// No dependencies; every other file refers to it by scoped names.
package ctqs_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int QDEPTH      = 2;
    localparam int QIDX_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef enum logic [1:0] {
        KIND_MOVE = 2'd0,
        KIND_LINE = 2'd1,
        KIND_QUAD = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind  kind;
        t_coord cx;
        t_coord cy;
        t_coord ex;
        t_coord ey;
        logic   last;
    } t_seg;

    // One accepted point that produced one or two segments
    typedef struct packed {
        logic two;
        t_seg s0;
        t_seg s1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // floor((a + b) / 2) at full precision
    function automatic t_coord mid_floor(input t_coord a, input t_coord b);
        logic signed [COORD_WIDTH:0] sum;
        sum = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        return sum[COORD_WIDTH:1];
    endfunction

endpackage

### hdl/ctqs_pt_if.sv
// Point channel interface: valid/ready handshake with one outline point.
// Depends on ctqs_pkg for the coordinate width.
interface ctqs_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctqs_pkg::COORD_WIDTH-1:0] point_x;
    logic signed [ctqs_pkg::COORD_WIDTH-1:0] point_y;
    logic                                point_on;
    logic                                contour_end;

    modport source (output valid, point_x, point_y, point_on, contour_end, input ready);
    modport sink   (input valid, point_x, point_y, point_on, contour_end, output ready);
endinterface

### hdl/ctqs_seg_if.sv
// Segment channel interface: valid/ready handshake with one path segment.
// Depends on ctqs_pkg for the coordinate width.
interface ctqs_seg_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          seg_kind;
    logic signed [ctqs_pkg::COORD_WIDTH-1:0] ctrl_x;
    logic signed [ctqs_pkg::COORD_WIDTH-1:0] ctrl_y;
    logic signed [ctqs_pkg::COORD_WIDTH-1:0] end_x;
    logic signed [ctqs_pkg::COORD_WIDTH-1:0] end_y;
    logic                                last_of_run;

    modport source (output valid, seg_kind, ctrl_x, ctrl_y, end_x, end_y, last_of_run,
                    input ready);
    modport sink   (input valid, seg_kind, ctrl_x, ctrl_y, end_x, end_y, last_of_run,
                    output ready);
endinterface

### hdl/ctqs_front.sv
// Front end: accepts points, tracks contour state and builds segment entries.
// Depends on ctqs_pkg and ctqs_pt_if.
module ctqs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ctqs_pt_if.sink           i_pt,
    output logic              o_push_valid,
    output ctqs_pkg::t_entry  o_push_entry,
    input  logic              i_push_ready
);

    logic             r_in_contour, n_in_contour;
    logic             r_held_valid, n_held_valid;
    ctqs_pkg::t_coord r_start_x, n_start_x;
    ctqs_pkg::t_coord r_start_y, n_start_y;
    ctqs_pkg::t_coord r_held_x, n_held_x;
    ctqs_pkg::t_coord r_held_y, n_held_y;

    logic             accept;
    logic             has_seg;
    ctqs_pkg::t_seg   seg_a;
    ctqs_pkg::t_seg   seg_b;
    ctqs_pkg::t_entry entry;

    assign i_pt.ready = i_push_ready;
    assign accept     = i_pt.valid && i_pt.ready;

    always_comb begin
        n_in_contour = r_in_contour;
        n_held_valid = r_held_valid;
        n_start_x    = r_start_x;
        n_start_y    = r_start_y;
        n_held_x     = r_held_x;
        n_held_y     = r_held_y;

        seg_a = '{kind: ctqs_pkg::KIND_LINE, cx: '0, cy: '0,
                  ex: i_pt.point_x, ey: i_pt.point_y, last: 1'b0};
        // closing segment back to the start
        seg_b = '{kind: ctqs_pkg::KIND_LINE, cx: '0, cy: '0,
                  ex: r_start_x, ey: r_start_y, last: 1'b1};
        has_seg = 1'b1;
        entry.two = 1'b0;

        if (!r_in_contour) begin
            seg_a.kind   = ctqs_pkg::KIND_MOVE;
            seg_b.ex     = i_pt.point_x;
            seg_b.ey     = i_pt.point_y;
            entry.two    = i_pt.contour_end;
            n_start_x    = i_pt.point_x;
            n_start_y    = i_pt.point_y;
            n_held_valid = 1'b0;
            n_in_contour = !i_pt.contour_end;
        end else if (i_pt.point_on) begin
            if (r_held_valid) begin
                seg_a.kind = ctqs_pkg::KIND_QUAD;
                seg_a.cx   = r_held_x;
                seg_a.cy   = r_held_y;
            end
            entry.two    = i_pt.contour_end;
            n_held_valid = 1'b0;
            n_in_contour = !i_pt.contour_end;
        end else begin
            seg_a = '{kind: ctqs_pkg::KIND_QUAD, cx: r_held_x, cy: r_held_y,
                      ex: ctqs_pkg::mid_floor(r_held_x, i_pt.point_x),
                      ey: ctqs_pkg::mid_floor(r_held_y, i_pt.point_y), last: 1'b0};
            seg_b.kind = ctqs_pkg::KIND_QUAD;
            seg_b.cx   = i_pt.point_x;
            seg_b.cy   = i_pt.point_y;
            entry.two  = r_held_valid && i_pt.contour_end;
            has_seg    = r_held_valid || i_pt.contour_end;
            // no held point: the closing quadratic is the only segment
            if (!r_held_valid) begin
                seg_a = seg_b;
            end
            if (i_pt.contour_end) begin
                n_held_valid = 1'b0;
                n_in_contour = 1'b0;
            end else begin
                n_held_x     = i_pt.point_x;
                n_held_y     = i_pt.point_y;
                n_held_valid = 1'b1;
            end
        end

        seg_a.last = !entry.two;
        entry.s0   = seg_a;
        entry.s1   = seg_b;
    end

    assign o_push_valid = i_pt.valid && has_seg;
    assign o_push_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_contour <= 1'b0;
            r_held_valid <= 1'b0;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_held_x     <= '0;
            r_held_y     <= '0;
        end else if (accept) begin
            r_in_contour <= n_in_contour;
            r_held_valid <= n_held_valid;
            r_start_x    <= n_start_x;
            r_start_y    <= n_start_y;
            r_held_x     <= n_held_x;
            r_held_y     <= n_held_y;
        end
    end

endmodule

### hdl/ctqs_queue.sv
// Short register queue between front end and back end.
// Depends on ctqs_pkg for entry type and depth.
module ctqs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  ctqs_pkg::t_entry  i_push_entry,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output ctqs_pkg::t_entry  o_pop_entry,
    input  logic              i_pop_ready,
    output ctqs_pkg::t_q_stat o_stat
);

    ctqs_pkg::t_entry r_mem [ctqs_pkg::QDEPTH];
    logic [ctqs_pkg::QIDX_W-1:0] r_wr, r_rd;
    logic [ctqs_pkg::QCNT_W-1:0] r_cnt;
    logic push, pop;

    assign o_stat.full   = (r_cnt == ctqs_pkg::QCNT_W'(ctqs_pkg::QDEPTH));
    assign o_stat.empty  = (r_cnt == '0);
    assign o_push_ready  = !o_stat.full;
    assign o_pop_valid   = !o_stat.empty;
    assign o_pop_entry   = r_mem[r_rd];
    assign push          = i_push_valid && o_push_ready;
    assign pop           = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == ctqs_pkg::QIDX_W'(ctqs_pkg::QDEPTH - 1)) ? '0 :
                        r_wr + ctqs_pkg::QIDX_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == ctqs_pkg::QIDX_W'(ctqs_pkg::QDEPTH - 1)) ? '0 :
                        r_rd + ctqs_pkg::QIDX_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + ctqs_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - ctqs_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

### hdl/ctqs_back.sv
// Back end: unpacks queue entries into one segment per transfer.
// Depends on ctqs_pkg and ctqs_seg_if.
module ctqs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    input  ctqs_pkg::t_entry  i_entry,
    output logic              o_pop_ready,
    ctqs_seg_if.source        o_seg
);

    logic           r_valid, n_valid;
    logic           r_pend, n_pend;
    ctqs_pkg::t_seg r_seg, n_seg;
    ctqs_pkg::t_seg r_pend_seg, n_pend_seg;
    logic           pop;

    // take a new entry only when no second segment waits
    assign o_pop_ready = !r_pend && (!r_valid || o_seg.ready);
    assign pop         = i_pop_valid && o_pop_ready;

    always_comb begin
        n_valid    = r_valid;
        n_pend     = r_pend;
        n_seg      = r_seg;
        n_pend_seg = r_pend_seg;
        if (r_valid && o_seg.ready) begin
            if (r_pend) begin
                n_seg  = r_pend_seg;
                n_pend = 1'b0;
            end else begin
                n_valid = 1'b0;
            end
        end
        if (pop) begin
            n_valid    = 1'b1;
            n_seg      = i_entry.s0;
            n_pend     = i_entry.two;
            n_pend_seg = i_entry.s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg      <= n_seg;
        r_pend_seg <= n_pend_seg;
    end

    assign o_seg.valid       = r_valid;
    assign o_seg.seg_kind    = r_seg.kind;
    assign o_seg.ctrl_x      = r_seg.cx;
    assign o_seg.ctrl_y      = r_seg.cy;
    assign o_seg.end_x       = r_seg.ex;
    assign o_seg.end_y       = r_seg.ey;
    assign o_seg.last_of_run = r_seg.last;

endmodule

### hdl/contour_to_quadratic_segments_core.sv
// Top level of the contour-to-quadratic segment core.
// Depends on ctqs_pkg, ctqs_pt_if, ctqs_seg_if, ctqs_front, ctqs_queue, ctqs_back.
//
//   channel   dir   handshake      payload
//   i_pt      in    valid/ready    point_x, point_y, point_on, contour_end
//   o_seg     out   valid/ready    seg_kind, ctrl_x, ctrl_y, end_x, end_y, last_of_run
//
// A point is accepted in any cycle the two-entry queue has room; it yields
// zero, one or two segments. The segment register sends one segment per cycle
// while o_seg.ready is high, so one-segment points then flow at one per cycle.
// The first segment of a point is registered in the queue, then in the segment register.
// Reset (synchronous, active low) clears contour state, queue and output valid.
// Output stalls fill the queue and then drop i_pt.ready; input idles never
// block segments already queued.
module contour_to_quadratic_segments_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctqs_pt_if.sink    i_pt,
    ctqs_seg_if.source o_seg
);

    // front end to queue
    logic              push_valid;
    logic              push_ready;
    ctqs_pkg::t_entry  push_entry;

    // queue to back end
    logic              pop_valid;
    logic              pop_ready;
    ctqs_pkg::t_entry  pop_entry;
    ctqs_pkg::t_q_stat q_stat;

    // Classify each point against the open contour and hold pending state
    ctqs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt         (i_pt),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    // Decouple the two sides so each can stall on its own
    ctqs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop_ready  (pop_ready),
        .o_stat       (q_stat)
    );

    // Send queued segments one transfer at a time
    ctqs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_entry     (pop_entry),
        .o_pop_ready (pop_ready),
        .o_seg       (o_seg)
    );

`ifndef NO_ASSERTIONS
    // Move and line segments carry a zero control point
    a_zero_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seg.valid && (o_seg.seg_kind == ctqs_pkg::KIND_MOVE ||
                         o_seg.seg_kind == ctqs_pkg::KIND_LINE))
        |-> (o_seg.ctrl_x == '0 && o_seg.ctrl_y == '0))
        else $error("move or line segment with nonzero control");

    // Present only the defined kind codes
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seg.valid |-> (o_seg.seg_kind == ctqs_pkg::KIND_MOVE ||
                         o_seg.seg_kind == ctqs_pkg::KIND_LINE ||
                         o_seg.seg_kind == ctqs_pkg::KIND_QUAD))
        else $error("invalid segment kind");

    // Input is stalled exactly when the queue is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_pt.ready) |-> (q_stat.full && !q_stat.empty))
        else $error("input stalled without a full queue");

    // A queued entry is presented to the back end
    a_queue_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_valid && pop_ready) |=> o_seg.valid)
        else $error("popped entry not presented");
`endif

endmodule

### verif/tb_top.sv
// Self-checking bench for contour_to_quadratic_segments_core: random outline
// points in, segments checked in order against an in-bench contour tracer.
// Depends on ctqs_pkg, ctqs_pt_if, ctqs_seg_if and the core itself.
module tb_top;

    localparam int IDLE_PCT     = 27;
    localparam int STALL_CYCLES = 80;
    localparam int WDOG_LIMIT   = 1000;
    localparam int RAND_POINTS  = 600;

    localparam ctqs_pkg::t_coord C_MAX = {1'b0, {(ctqs_pkg::COORD_WIDTH-1){1'b1}}};
    localparam ctqs_pkg::t_coord C_MIN = {1'b1, {(ctqs_pkg::COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        ctqs_pkg::t_coord x;
        ctqs_pkg::t_coord y;
        logic             on;
        logic             closes;
    } t_outline_pt;

    logic i_clk;
    logic i_rst_n;

    ctqs_pt_if  pt_bus ();
    ctqs_seg_if seg_bus ();

    contour_to_quadratic_segments_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_bus.sink),
        .o_seg   (seg_bus.source)
    );

    t_outline_pt      outline_pts[$];
    ctqs_pkg::t_seg   pending_segs[$];
    int               pts_taken   = 0;
    int               fail_cnt    = 0;
    int               idle_cycles = 0;

    // Contour tracer state
    logic             trc_open    = 1'b0;
    ctqs_pkg::t_coord trc_start_x = '0;
    ctqs_pkg::t_coord trc_start_y = '0;
    logic             trc_held    = 1'b0;
    ctqs_pkg::t_coord trc_held_x  = '0;
    ctqs_pkg::t_coord trc_held_y  = '0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // floor of the average of two coordinates, sum kept one bit wider
    function automatic ctqs_pkg::t_coord coord_midpoint(input ctqs_pkg::t_coord a,
                                                        input ctqs_pkg::t_coord b);
        logic signed [ctqs_pkg::COORD_WIDTH:0] sum;
        sum = a + b;
        return ctqs_pkg::t_coord'(sum >>> 1);
    endfunction

    function automatic void queue_seg(input ctqs_pkg::t_kind kind,
                                      input ctqs_pkg::t_coord cx, input ctqs_pkg::t_coord cy,
                                      input ctqs_pkg::t_coord ex, input ctqs_pkg::t_coord ey);
        ctqs_pkg::t_seg s;
        s.kind = kind;
        s.cx   = cx;
        s.cy   = cy;
        s.ex   = ex;
        s.ey   = ey;
        s.last = 1'b0;
        pending_segs.push_back(s);
    endfunction

    // Advance the tracer by one accepted point and queue the segments it yields
    function automatic void trace_point(input t_outline_pt p);
        int n_prior;
        n_prior = pending_segs.size();
        if (!trc_open) begin
            queue_seg(ctqs_pkg::KIND_MOVE, '0, '0, p.x, p.y);
            trc_start_x = p.x;
            trc_start_y = p.y;
            trc_held    = 1'b0;
            trc_open    = 1'b1;
            if (p.closes) begin
                queue_seg(ctqs_pkg::KIND_LINE, '0, '0, trc_start_x, trc_start_y);
                trc_open = 1'b0;
            end
        end else if (p.on) begin
            if (trc_held)
                queue_seg(ctqs_pkg::KIND_QUAD, trc_held_x, trc_held_y, p.x, p.y);
            else
                queue_seg(ctqs_pkg::KIND_LINE, '0, '0, p.x, p.y);
            trc_held = 1'b0;
            if (p.closes) begin
                queue_seg(ctqs_pkg::KIND_LINE, '0, '0, trc_start_x, trc_start_y);
                trc_open = 1'b0;
            end
        end else begin
            if (trc_held)
                queue_seg(ctqs_pkg::KIND_QUAD, trc_held_x, trc_held_y,
                          coord_midpoint(trc_held_x, p.x), coord_midpoint(trc_held_y, p.y));
            if (p.closes) begin
                queue_seg(ctqs_pkg::KIND_QUAD, p.x, p.y, trc_start_x, trc_start_y);
                trc_held = 1'b0;
                trc_open = 1'b0;
            end else begin
                trc_held_x = p.x;
                trc_held_y = p.y;
                trc_held   = 1'b1;
            end
        end
        if (pending_segs.size() > n_prior)
            pending_segs[pending_segs.size()-1].last = 1'b1;
    endfunction

    function automatic void add_pt(input int x, input int y, input int on, input int closes);
        t_outline_pt p;
        p.x      = ctqs_pkg::t_coord'(x);
        p.y      = ctqs_pkg::t_coord'(y);
        p.on     = on[0];
        p.closes = closes[0];
        outline_pts.push_back(p);
    endfunction

    // Mix extremes, small values near zero and full-range values
    function automatic ctqs_pkg::t_coord rand_coord();
        case ($urandom_range(0, 9))
            0:       return C_MAX;
            1:       return C_MIN;
            2, 3:    return ctqs_pkg::t_coord'(int'($urandom_range(0, 511)) - 256);
            default: return ctqs_pkg::t_coord'($urandom());
        endcase
    endfunction

    // No idling on either side while this window of points goes through
    function automatic logic calm_window();
        return (pts_taken >= 150 && pts_taken < 280);
    endfunction

    // Point driver: offer the next pending point, hold it until transferred
    always @(posedge i_clk) begin : drive_pts
        t_outline_pt p;
        if (!i_rst_n) begin
            pt_bus.valid <= 1'b0;
        end else begin
            if (pt_bus.valid && pt_bus.ready) begin
                p.x      = pt_bus.point_x;
                p.y      = pt_bus.point_y;
                p.on     = pt_bus.point_on;
                p.closes = pt_bus.contour_end;
                trace_point(p);
                pts_taken <= pts_taken + 1;
            end
            if (!pt_bus.valid || pt_bus.ready) begin
                if (outline_pts.size() != 0 &&
                    (calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    p = outline_pts.pop_front();
                    pt_bus.point_x     <= p.x;
                    pt_bus.point_y     <= p.y;
                    pt_bus.point_on    <= p.on;
                    pt_bus.contour_end <= p.closes;
                    pt_bus.valid       <= 1'b1;
                end else begin
                    pt_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Segment monitor: check each transfer, then pick ready for the next cycle
    int   stall_left;
    logic stall_done;

    always @(posedge i_clk) begin : watch_segs
        ctqs_pkg::t_seg exp_seg;
        if (!i_rst_n) begin
            seg_bus.ready <= 1'b0;
            stall_left    <= 0;
            stall_done    <= 1'b0;
        end else begin
            if (seg_bus.valid && seg_bus.ready) begin
                if (pending_segs.size() == 0) begin
                    $error("unexpected segment: kind %0d end (%0d, %0d)",
                           seg_bus.seg_kind, seg_bus.end_x, seg_bus.end_y);
                    fail_cnt++;
                end else begin
                    exp_seg = pending_segs.pop_front();
                    if (seg_bus.seg_kind !== exp_seg.kind) begin
                        $error("seg_kind: expected %0d, got %0d", exp_seg.kind, seg_bus.seg_kind);
                        fail_cnt++;
                    end
                    if (seg_bus.ctrl_x !== exp_seg.cx) begin
                        $error("ctrl_x: expected %0d, got %0d", exp_seg.cx, seg_bus.ctrl_x);
                        fail_cnt++;
                    end
                    if (seg_bus.ctrl_y !== exp_seg.cy) begin
                        $error("ctrl_y: expected %0d, got %0d", exp_seg.cy, seg_bus.ctrl_y);
                        fail_cnt++;
                    end
                    if (seg_bus.end_x !== exp_seg.ex) begin
                        $error("end_x: expected %0d, got %0d", exp_seg.ex, seg_bus.end_x);
                        fail_cnt++;
                    end
                    if (seg_bus.end_y !== exp_seg.ey) begin
                        $error("end_y: expected %0d, got %0d", exp_seg.ey, seg_bus.end_y);
                        fail_cnt++;
                    end
                    if (seg_bus.last_of_run !== exp_seg.last) begin
                        $error("last_of_run: expected %0d, got %0d",
                               exp_seg.last, seg_bus.last_of_run);
                        fail_cnt++;
                    end
                end
            end
            // Hold off once for a long stretch so the core backs up into its input
            if (!stall_done && pts_taken >= 400) begin
                stall_done    <= 1'b1;
                stall_left    <= STALL_CYCLES;
                seg_bus.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left    <= stall_left - 1;
                seg_bus.ready <= 1'b0;
            end else begin
                seg_bus.ready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: count cycles with work outstanding but no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n ||
            (pt_bus.valid && pt_bus.ready) || (seg_bus.valid && seg_bus.ready) ||
            (outline_pts.size() == 0 && !pt_bus.valid && pending_segs.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int len;
        int off_bias;
        i_rst_n = 1'b0;

        // Single-point contours, on and off the curve
        add_pt(100, -100, 1, 1);
        add_pt(C_MAX, C_MIN, 0, 1);
        // Off-curve start, line, then off-curve runs with midpoints at the extremes
        add_pt(C_MIN, C_MAX, 0, 0);
        add_pt(5, 5, 1, 0);
        add_pt(C_MAX, C_MAX, 0, 0);
        add_pt(C_MAX, C_MAX, 0, 0);
        add_pt(C_MIN, C_MIN, 0, 0);
        add_pt(C_MIN, C_MIN, 0, 0);
        // On-curve end after a held control: quadratic, then line to start
        add_pt(0, 0, 1, 1);
        // Odd negative sums round toward minus infinity; off-curve close with held
        add_pt(-3, 7, 1, 0);
        add_pt(-3, -5, 0, 0);
        add_pt(0, 2, 0, 0);
        add_pt(C_MIN, C_MAX, 0, 1);
        // Lines only, closing with a line
        add_pt(0, 0, 1, 0);
        add_pt(C_MAX, C_MAX, 1, 1);
        // Off-curve close with nothing held
        add_pt(1, 1, 1, 0);
        add_pt(2, 3, 0, 1);
        add_pt(-1, -1, 1, 0);
        add_pt(C_MIN, C_MIN, 1, 1);

        // Random contours with varied on/off mix; a few stray points as noise
        while (outline_pts.size() < RAND_POINTS + 19) begin
            if ($urandom_range(0, 9) == 0) begin
                add_pt(rand_coord(), rand_coord(), int'($urandom_range(0, 1)),
                       int'($urandom_range(0, 1)));
            end else begin
                len      = $urandom_range(1, 8);
                off_bias = $urandom_range(20, 80);
                for (int i = 0; i < len; i++)
                    add_pt(rand_coord(), rand_coord(), int'($urandom_range(0, 99) >= off_bias),
                           int'(i == len - 1));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every point transferred, every segment seen, then idle cycles before the verdict
        while (outline_pts.size() != 0 || pt_bus.valid) @(posedge i_clk);
        while (pending_segs.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
